// ----- rtl/imsu_pkg.sv -----
// Package: shared types, field widths and codes for the Ising spin-update block.
`timescale 1ns / 1ps

package imsu_pkg;

   // Field widths of the transaction payloads
   localparam int CMD_W    = 2;
   localparam int SITE_W   = 12;
   localparam int RND_W    = 32;
   localparam int LIMIT_W  = 33;
   localparam int LSUM_W   = 4;
   localparam int ENERGY_W = 15;
   localparam int MAG_W    = 14;
   localparam int COUNT_W  = 32;

   // Register port geometry: 64-bit registers at byte addresses 0 and 8
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   // Register indexes
   localparam int CSR_LIMIT_TWO  = 0;
   localparam int CSR_LIMIT_FOUR = 1;

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_ATTEMPT = 2'd0,
      CMD_MEASURE = 2'd1,
      CMD_CLEAR   = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [SITE_W-1:0] site_index;
      logic [RND_W-1:0]  random_fraction;
   } req_type;

   typedef struct packed {
      logic                       flipped;
      logic signed [LSUM_W-1:0]   local_sum;
      logic signed [ENERGY_W-1:0] energy;
      logic signed [MAG_W-1:0]    magnetisation;
      logic [COUNT_W-1:0]         attempt_count;
      logic [COUNT_W-1:0]         flip_count;
   } rsp_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_INIT_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_READ_OWN,
      ST_READ_ROW,
      ST_READ_COL,
      ST_EVAL,
      ST_WALK,
      ST_WALK_DRAIN,
      ST_CMD_CLEAR,
      ST_DONE
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic reduce;
      logic read_own;
      logic read_row;
      logic read_col;
      logic eval;
      logic walk_read;
      logic clear_write;
      logic clear_counts;
      logic load_rsp;
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic walk_last;
      logic rsp_free;
   } ctl_status_type;

endpackage

// ----- rtl/imsu_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
`timescale 1ns / 1ps

module imsu_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read ports
   always_ff @(posedge clock) begin
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ----- rtl/imsu_csr.sv -----
// Register port: the two acceptance thresholds behind an APB-style interface.
`timescale 1ns / 1ps

module imsu_csr import imsu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [LIMIT_W-1:0]    limit_two,
   output logic [LIMIT_W-1:0]    limit_four
);

   logic [LIMIT_W-1:0] limit_two_ff, limit_two_in;
   logic [LIMIT_W-1:0] limit_four_ff, limit_four_in;
   logic               wr_strobe;
   logic               reg_index;

   assign csr_pready = 1'b1;
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // registers sit on 8-byte boundaries
   assign reg_index  = csr_paddr[CSR_ADDR_W-1];

   // Write decode
   always_comb begin
      limit_two_in  = limit_two_ff;
      limit_four_in = limit_four_ff;
      if (wr_strobe) begin
         if (reg_index == 1'(CSR_LIMIT_FOUR)) begin
            limit_four_in = csr_pwdata[LIMIT_W-1:0];
         end else if (reg_index == 1'(CSR_LIMIT_TWO)) begin
            limit_two_in = csr_pwdata[LIMIT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_two_ff  <= '0;
         limit_four_ff <= '0;
      end else begin
         limit_two_ff  <= limit_two_in;
         limit_four_ff <= limit_four_in;
      end
   end

   // Read mux
   assign csr_prdata = (reg_index == 1'(CSR_LIMIT_FOUR)) ?
                       CSR_DATA_W'(limit_four_ff) : CSR_DATA_W'(limit_two_ff);

   assign limit_two  = limit_two_ff;
   assign limit_four = limit_four_ff;

endmodule

// ----- rtl/imsu_ctrl.sv -----
// Controller: sequences attempts, lattice walks and clearing sweeps.
`timescale 1ns / 1ps

module imsu_ctrl import imsu_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_command,
   input  ctl_status_type   status,
   output logic             req_stall,
   output ctl_cmd_type      ctl
);

   state_type state_ff, state_in;

   // State register; reset starts the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_INIT_CLEAR: begin
            ctl.clear_write = 1'b1;
            if (status.walk_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.load = 1'b1;
               unique case (req_command)
                  CMD_ATTEMPT: state_in = ST_REDUCE;
                  CMD_MEASURE: state_in = ST_WALK;
                  CMD_CLEAR:   state_in = ST_CMD_CLEAR;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_REDUCE: begin
            ctl.reduce = 1'b1;
            state_in   = ST_READ_OWN;
         end
         ST_READ_OWN: begin
            ctl.read_own = 1'b1;
            state_in     = ST_READ_ROW;
         end
         ST_READ_ROW: begin
            ctl.read_row = 1'b1;
            state_in     = ST_READ_COL;
         end
         ST_READ_COL: begin
            ctl.read_col = 1'b1;
            state_in     = ST_EVAL;
         end
         ST_EVAL: begin
            ctl.eval = 1'b1;
            state_in = ST_DONE;
         end
         ST_WALK: begin
            ctl.walk_read = 1'b1;
            if (status.walk_last) begin
               state_in = ST_WALK_DRAIN;
            end
         end
         ST_WALK_DRAIN: begin
            // last site's spins land in the accumulators
            state_in = ST_DONE;
         end
         ST_CMD_CLEAR: begin
            ctl.clear_write  = 1'b1;
            ctl.clear_counts = 1'b1;
            if (status.walk_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               ctl.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT_CLEAR;
         end
      endcase
   end

endmodule

// ----- rtl/imsu_datapath.sv -----
// Datapath: spin store, site reduction, neighbor reads, acceptance test and lattice sums.
`timescale 1ns / 1ps

module imsu_datapath import imsu_pkg::*; #(
   parameter int SIDE = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  ctl_cmd_type        ctl,
   output ctl_status_type     status,
   input  req_type            req_data,
   input  logic [LIMIT_W-1:0] limit_two,
   input  logic [LIMIT_W-1:0] limit_four,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data
);

   localparam int NSITES      = SIDE * SIDE;
   localparam int ADDR_W      = $clog2(NSITES);
   localparam int AW1         = ADDR_W + 1;
   localparam int RECIP_SHIFT = 24;
   localparam int PROD_W      = RECIP_SHIFT + SITE_W;
   localparam int RECIP       = (1 << RECIP_SHIFT) / NSITES;
   localparam int MUL_W       = SITE_W + AW1;

   localparam logic [AW1-1:0]   N_C    = AW1'(NSITES);
   localparam logic [AW1-1:0]   SIDE_C = AW1'(SIDE);
   localparam logic [MUL_W-1:0] N_MUL  = MUL_W'(NSITES);

   // Energy contribution of one bond: -s_a * s_b
   function automatic logic [ENERGY_W-1:0] bond(input logic a, input logic b);
      return (a == b) ? {ENERGY_W{1'b1}} : ENERGY_W'(1);
   endfunction

   // Transaction capture
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [SITE_W-1:0] site_ff, site_in;
   logic [RND_W-1:0]  rnd_ff, rnd_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [ADDR_W-1:0] k_ff, k_in;

   // Neighbor spins
   logic own_ff, own_in;
   logic n_left_ff, n_left_in;
   logic n_right_ff, n_right_in;
   logic n_up_ff, n_up_in;

   // Walk counter and accumulation pipeline
   logic [ADDR_W-1:0] walk_ff, walk_in;
   logic              acc_valid_ff, acc_valid_in;
   logic              acc_first_ff, acc_first_in;
   logic              acc_last_ff, acc_last_in;
   logic              first_spin_ff, first_spin_in;
   logic              prev_spin_ff, prev_spin_in;
   logic [ENERGY_W-1:0] energy_ff, energy_in;
   logic [MAG_W-1:0]    mag_ff, mag_in;

   // Attempt outcome and counters
   logic              flip_ff, flip_in;
   logic [LSUM_W-1:0] lsum_ff, lsum_in;
   logic [COUNT_W-1:0] cnt_attempt_ff, cnt_attempt_in;
   logic [COUNT_W-1:0] cnt_flip_ff, cnt_flip_in;

   // Result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // Spin store ports
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [0:0]        wr_data;
   logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
   logic [0:0]        rd_data_a, rd_data_b;

   // Address arithmetic
   logic [MUL_W-1:0]  quot;
   logic [MUL_W-1:0]  rem;
   logic [AW1-1:0]    k_ext, walk_ext;
   logic [ADDR_W-1:0] k_left, k_right, k_up, k_down, walk_down;

   // Acceptance test
   logic [2:0] eq_cnt;
   logic       take;
   logic       walk_last;

   imsu_ram #(
      .WIDTH (1),
      .DEPTH (NSITES)
   ) u_spin_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // Site reduction modulo the site count: reciprocal estimate, one correction
   assign prod_in = PROD_W'(req_data.site_index) * PROD_W'(RECIP);
   assign quot    = MUL_W'(prod_ff[RECIP_SHIFT +: SITE_W]);
   assign rem     = MUL_W'(site_ff) - quot * N_MUL;
   assign k_in    = (rem >= N_MUL) ? ADDR_W'(rem - N_MUL) : ADDR_W'(rem);

   // Helical neighbor addresses
   assign k_ext    = {1'b0, k_ff};
   assign walk_ext = {1'b0, walk_ff};
   assign k_left   = (k_ff == '0) ? ADDR_W'(N_C - 1'b1) : ADDR_W'(k_ext - 1'b1);
   assign k_right  = (k_ext == N_C - 1'b1) ? '0 : ADDR_W'(k_ext + 1'b1);
   assign k_up     = (k_ext < SIDE_C) ? ADDR_W'(k_ext + N_C - SIDE_C)
                                      : ADDR_W'(k_ext - SIDE_C);
   assign k_down   = (k_ext >= N_C - SIDE_C) ? ADDR_W'(k_ext + SIDE_C - N_C)
                                             : ADDR_W'(k_ext + SIDE_C);
   assign walk_down = (walk_ext >= N_C - SIDE_C) ? ADDR_W'(walk_ext + SIDE_C - N_C)
                                                 : ADDR_W'(walk_ext + SIDE_C);
   assign walk_last = (walk_ext == N_C - 1'b1);

   // Read address selection
   always_comb begin
      rd_addr_a = walk_ff;
      rd_addr_b = walk_down;
      priority if (ctl.read_own) begin
         rd_addr_a = k_ff;
         rd_addr_b = k_left;
      end else if (ctl.read_row) begin
         rd_addr_a = k_right;
         rd_addr_b = k_up;
      end else if (ctl.read_col) begin
         rd_addr_a = k_down;
      end else begin
         // lattice walk: site and the one a row ahead
         rd_addr_a = walk_ff;
         rd_addr_b = walk_down;
      end
   end

   // Count neighbors aligned with the own spin; down neighbor arrives now
   assign eq_cnt = {2'b0, own_ff ~^ n_left_ff} + {2'b0, own_ff ~^ n_right_ff}
                 + {2'b0, own_ff ~^ n_up_ff}   + {2'b0, own_ff ~^ rd_data_a[0]};

   // Flip on local sum <= 0, else compare against the threshold
   always_comb begin
      priority if (eq_cnt <= 3'd2) begin
         take = 1'b1;
      end else if (eq_cnt == 3'd3) begin
         take = {1'b0, rnd_ff} < limit_two;
      end else begin
         take = {1'b0, rnd_ff} < limit_four;
      end
   end

   // Write port: clearing sweep or flip write-back
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = walk_ff;
      wr_data = 1'b1;
      priority if (ctl.clear_write) begin
         wr_en = 1'b1;
      end else if (ctl.eval) begin
         wr_en   = take;
         wr_addr = k_ff;
         wr_data = ~own_ff;
      end else begin
         wr_en = 1'b0;
      end
   end

   // Capture, neighbor and attempt registers
   always_comb begin
      cmd_in     = cmd_ff;
      site_in    = site_ff;
      rnd_in     = rnd_ff;
      own_in     = own_ff;
      n_left_in  = n_left_ff;
      n_right_in = n_right_ff;
      n_up_in    = n_up_ff;
      flip_in    = flip_ff;
      lsum_in    = lsum_ff;
      if (ctl.load) begin
         cmd_in  = req_data.command;
         site_in = req_data.site_index;
         rnd_in  = req_data.random_fraction;
      end
      if (ctl.read_row) begin
         own_in    = rd_data_a[0];
         n_left_in = rd_data_b[0];
      end
      if (ctl.read_col) begin
         n_right_in = rd_data_a[0];
         n_up_in    = rd_data_b[0];
      end
      if (ctl.eval) begin
         flip_in = take;
         lsum_in = LSUM_W'({eq_cnt, 1'b0}) - LSUM_W'(4);
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      site_ff    <= site_in;
      rnd_ff     <= rnd_in;
      own_ff     <= own_in;
      n_left_ff  <= n_left_in;
      n_right_ff <= n_right_in;
      n_up_ff    <= n_up_in;
      flip_ff    <= flip_in;
      lsum_ff    <= lsum_in;
      if (ctl.load) begin
         prod_ff <= prod_in;
      end
      if (ctl.reduce) begin
         k_ff <= k_in;
      end
   end

   // Walk counter: shared by measure and clearing sweeps, wraps to zero
   always_comb begin
      walk_in      = walk_ff;
      acc_valid_in = ctl.walk_read;
      acc_first_in = (walk_ff == '0);
      acc_last_in  = walk_last;
      if (ctl.walk_read || ctl.clear_write) begin
         walk_in = walk_last ? '0 : ADDR_W'(walk_ext + 1'b1);
      end
   end

   // Energy and magnetisation accumulation, one site per cycle
   always_comb begin
      energy_in     = energy_ff;
      mag_in        = mag_ff;
      first_spin_in = first_spin_ff;
      prev_spin_in  = prev_spin_ff;
      if (ctl.load) begin
         energy_in = '0;
         mag_in    = '0;
      end else if (acc_valid_ff) begin
         energy_in = energy_ff + bond(rd_data_a[0], rd_data_b[0])
                   + (acc_first_ff ? '0 : bond(prev_spin_ff, rd_data_a[0]))
                   + (acc_last_ff ? bond(rd_data_a[0], first_spin_ff) : '0);
         mag_in    = mag_ff + (rd_data_a[0] ? MAG_W'(1) : {MAG_W{1'b1}});
         prev_spin_in = rd_data_a[0];
         if (acc_first_ff) begin
            first_spin_in = rd_data_a[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      energy_ff     <= energy_in;
      mag_ff        <= mag_in;
      first_spin_ff <= first_spin_in;
      prev_spin_ff  <= prev_spin_in;
      acc_first_ff  <= acc_first_in;
      acc_last_ff   <= acc_last_in;
   end

   // Saturating counters
   always_comb begin
      cnt_attempt_in = cnt_attempt_ff;
      cnt_flip_in    = cnt_flip_ff;
      if (ctl.clear_counts) begin
         cnt_attempt_in = '0;
         cnt_flip_in    = '0;
      end else if (ctl.eval) begin
         if (cnt_attempt_ff != '1) begin
            cnt_attempt_in = cnt_attempt_ff + 1'b1;
         end
         if (take && (cnt_flip_ff != '1)) begin
            cnt_flip_in = cnt_flip_ff + 1'b1;
         end
      end
   end

   // Result register; fields a command does not produce read as zero
   always_comb begin
      rsp_valid_in = ctl.load_rsp || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (ctl.load_rsp) begin
         rsp_data_in               = '0;
         rsp_data_in.attempt_count = cnt_attempt_ff;
         rsp_data_in.flip_count    = cnt_flip_ff;
         if (cmd_ff == CMD_ATTEMPT) begin
            rsp_data_in.flipped   = flip_ff;
            rsp_data_in.local_sum = lsum_ff;
         end
         if (cmd_ff == CMD_MEASURE) begin
            rsp_data_in.energy        = energy_ff;
            rsp_data_in.magnetisation = mag_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff        <= '0;
         acc_valid_ff   <= 1'b0;
         cnt_attempt_ff <= '0;
         cnt_flip_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         walk_ff        <= walk_in;
         acc_valid_ff   <= acc_valid_in;
         cnt_attempt_ff <= cnt_attempt_in;
         cnt_flip_ff    <= cnt_flip_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign status.walk_last = walk_last;
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;

   // A new result never overwrites one the receiver has not taken
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a stalled transaction");

   // Accepted flips can never outnumber attempts
   a_flips_le_attempts: assert property (@(posedge clock) disable iff (reset)
      cnt_flip_ff <= cnt_attempt_ff)
      else $error("flip counter ahead of attempt counter");

   // Energy is a sum of an even number of unit bonds
   a_energy_even: assert property (@(posedge clock) disable iff (reset)
      (ctl.load_rsp && (cmd_ff == CMD_MEASURE)) |-> !energy_ff[0])
      else $error("odd lattice energy");

   // Reduced site lies inside the lattice before its reads start
   a_site_in_range: assert property (@(posedge clock) disable iff (reset)
      ctl.read_own |-> (k_ext < N_C))
      else $error("reduced site index out of range");

endmodule

// ----- rtl/ising_metropolis_spin_update_top.sv -----
// Top level: Metropolis single-spin-flip engine for a helical 2D Ising lattice.
//
// Commands arrive on the req_ channel (valid/stall); each accepted transaction
// yields exactly one rsp_ transaction carrying the outcome and both counters.
// The thresholds for local sums 2 and 4 are written over the csr_ port
// (64-bit registers at byte addresses 0 and 8); the user must write them
// only while the block is idle, and the block has no check of its own for it.
// Flip attempt: site reduction, three two-port reads of the spin store (five
// spins) and a write-back when the flip is taken, then the result is loaded.
// Measure: one site per cycle through the spin store.
// Clear command: one spin store entry written per cycle.
// Reset: all spins are set up by a sweep over all SIDE*SIDE sites (4096 at
// the default size) during which req_stall stays high; counters and
// thresholds clear at once.
// A result waits in an output register while rsp_stall is high; the block
// still takes one new transaction, and holds its own result until the
// register is free.
`timescale 1ns / 1ps

module ising_metropolis_spin_update_top import imsu_pkg::*; #(
   parameter int SIDE = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   ctl_cmd_type        ctl;
   ctl_status_type     status;
   logic [LIMIT_W-1:0] limit_two;
   logic [LIMIT_W-1:0] limit_four;

   imsu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .limit_two   (limit_two),
      .limit_four  (limit_four)
   );

   imsu_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .status      (status),
      .req_stall   (req_stall),
      .ctl         (ctl)
   );

   imsu_datapath #(
      .SIDE (SIDE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .status     (status),
      .req_data   (req_data),
      .limit_two  (limit_two),
      .limit_four (limit_four),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
